@@ rtl/encoder_speed_pi_motor_drive_macros.svh @@
// Assertion macros shared by the speed loop RTL.
`ifndef ENCODER_SPEED_PI_MOTOR_DRIVE_MACROS_SVH
`define ENCODER_SPEED_PI_MOTOR_DRIVE_MACROS_SVH

// Concurrent implication checked on every rising clock edge outside reset.
`define ESPMD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// A condition that must never hold outside reset.
`define ESPMD_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");

`endif

@@ rtl/espmd_pkg.sv @@
// ----------------------------------------------------------------------------
// espmd_pkg
// Constants and register indexes of the encoder speed loop.
// ----------------------------------------------------------------------------
package espmd_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSES_PER_REV   = 3'd0,
      CSR_KP_UV            = 3'd1,
      CSR_INT_GAIN_Q16     = 3'd2,
      CSR_VMAX_MV          = 3'd3,
      CSR_REVERSE_POLARITY = 3'd4
   } csr_index_type;

   // Speed numerator: 360 deg * 16 * 1e6 us.
   localparam logic [63:0] SPEED_NUM  = 64'd5760000000;
   localparam logic [23:0] SPEED_FULL = 24'd8388607;
   // Position scale: 360 deg * 16.
   localparam logic [19:0] POS_SCALE  = 20'd5760;
   // The drive divisor 16000 * 65536 is 125 * 2^23. A digit value below 32000
   // divided by 125 equals floor(v * 33555 / 2^22).
   localparam logic [19:0] C125_RECIP = 20'd33555;

   localparam logic [15:0] PPR_RESET  = 16'd1080;
   localparam logic [19:0] KP_RESET   = 20'd14000;
   localparam logic [15:0] IG_RESET   = 16'd1049;
   localparam logic [15:0] VMAX_RESET = 16'd11100;

endpackage

@@ rtl/espmd_if.sv @@
// ----------------------------------------------------------------------------
// espmd_req_if / espmd_rsp_if
// Valid/ready channels for encoder and control transactions and their results.
// ----------------------------------------------------------------------------
interface espmd_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [31:0]        time_us;
   logic               channel_b;
   logic signed [23:0] target_speed;

   modport source (output valid, action, time_us, channel_b, target_speed, input ready);
   modport sink   (input valid, action, time_us, channel_b, target_speed, output ready);
endinterface

interface espmd_rsp_if #(parameter int DUTY_BITS = 10);
   logic                 valid;
   logic                 ready;
   logic                 kind;
   logic signed [31:0]   tick_total;
   logic signed [23:0]   speed_median;
   logic signed [47:0]   position_q4;
   logic signed [16:0]   drive_mv;
   logic [DUTY_BITS-1:0] duty;
   logic                 pin_a;
   logic                 pin_b;

   modport source (output valid, kind, tick_total, speed_median, position_q4, drive_mv,
                   duty, pin_a, pin_b, input ready);
   modport sink   (input valid, kind, tick_total, speed_median, position_q4, drive_mv,
                   duty, pin_a, pin_b, output ready);
endinterface

@@ rtl/encoder_speed_pi_motor_drive.sv @@
// ----------------------------------------------------------------------------
// encoder_speed_pi_motor_drive
// Encoder speed and position with a PI speed controller and PWM drive.
// ----------------------------------------------------------------------------
// Edge and control results come from the 64-step restoring divider and the 8-bit
// digit steps of the divide by 125. A new transaction is accepted only in S_IDLE,
// after the last one is through. A result that waits in the output register stalls
// the next transaction only at its last step.
// Reset (synchronous, active high) restores the register defaults and zeroes loop state.
`include "encoder_speed_pi_motor_drive_macros.svh"

module encoder_speed_pi_motor_drive #(
   parameter int DUTY_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   espmd_req_if.sink                             req_ch,
   espmd_rsp_if.source                           rsp_ch,
   input  logic                                  csr_we,
   input  logic [espmd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [espmd_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam logic [DUTY_BITS-1:0] FS = '1;

   typedef enum logic [4:0] {
      S_IDLE, S_EMUL, S_SPD, S_SPDF, S_TSUM, S_TMUL, S_TCOMB, S_MF, S_KQ, S_KR,
      S_KRD, S_KRS, S_KRF, S_DMUL, S_DDIV, S_DUTYF, S_PMUL, S_PDIV, S_POSF, S_DIV,
      S_CMUL, S_CSTEP, S_DONE
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic [15:0] ppr_ff, ig_ff, vmax_ff;
   logic [19:0] kp_ff;
   logic        rev_ff;

   // loop state
   logic [31:0]        last_ff, count_ff;
   logic signed [23:0] spd_last_ff, spd_prev_ff, median_ff;
   logic signed [47:0] sum_ff;

   // work registers
   logic               kind_ff, chb_ff, neg_ff;
   logic [31:0]        period_ff;
   logic signed [24:0] e_ff;
   logic [67:0]        prod_ff;
   logic [33:0]        q_ff;
   logic [22:0]        low_ff;
   logic [19:0]        klo_ff;
   logic [53:0]        kq_ff;
   logic [15:0]        mag_ff;
   logic signed [16:0] drive_ff;
   logic [DUTY_BITS-1:0] duty_ff;
   logic               pa_ff, pb_ff;
   logic signed [47:0] pos_ff;

   // shared divider
   logic [48:0] rem_ff;
   logic [63:0] quo_ff;
   logic [47:0] dsr_ff;
   logic [5:0]  dcnt_ff;

   // divide by 125, one 8-bit digit per S_CMUL/S_CSTEP pass
   logic [47:0] c_x_ff, c_q_ff;
   logic [6:0]  c_r_ff;
   logic [2:0]  ccnt_ff;

   // output register
   logic                 rv_ff, ok_ff, opa_ff, opb_ff;
   logic signed [31:0]   otick_ff;
   logic signed [23:0]   omed_ff;
   logic signed [47:0]   opos_ff;
   logic signed [16:0]   odrv_ff;
   logic [DUTY_BITS-1:0] oduty_ff;

   logic [47:0] mul_a;
   logic [19:0] mul_b;
   logic [15:0] ppr_eff;
   logic [47:0] sum_abs;
   logic [31:0] cnt_abs;
   logic [48:0] div_try;
   logic        div_ge;
   logic [14:0] c_v;

   assign ppr_eff = (ppr_ff == 16'd0) ? 16'd1 : ppr_ff;
   assign sum_abs = sum_ff[47] ? (48'd0 - sum_ff) : sum_ff;
   assign cnt_abs = count_ff[31] ? (32'd0 - count_ff) : count_ff;
   assign div_try = {rem_ff[47:0], quo_ff[63]};
   assign div_ge  = div_try >= {1'b0, dsr_ff};
   assign c_v     = {c_r_ff, c_x_ff[47:40]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_EMUL: begin
            mul_a = {16'd0, period_ff};
            mul_b = {4'd0, ppr_eff};
         end
         S_TMUL: begin
            mul_a = sum_abs;
            mul_b = {4'd0, ig_ff};
         end
         S_KQ: begin
            mul_a = {14'd0, q_ff};
            mul_b = kp_ff;
         end
         S_KR: begin
            mul_a = {25'd0, low_ff};
            mul_b = kp_ff;
         end
         S_KRD: begin
            mul_a = {41'd0, c_r_ff};
            mul_b = kp_ff;
         end
         S_CMUL: begin
            mul_a = {33'd0, c_v};
            mul_b = espmd_pkg::C125_RECIP;
         end
         S_DMUL: begin
            mul_a = {32'd0, vmax_ff - mag_ff};
            mul_b = {{(20-DUTY_BITS){1'b0}}, FS};
         end
         S_PMUL: begin
            mul_a = {16'd0, cnt_abs};
            mul_b = espmd_pkg::POS_SCALE;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      logic signed [23:0] v, mn, mx, lo2;
      logic [23:0]        mg;
      logic signed [48:0] s49;
      logic [63:0]        m1, m2, mm;
      logic [54:0]        mfull;
      logic [15:0]        mg16;
      logic               ng;
      logic [7:0]         qd;
      logic [14:0]        crem;
      prod_ff <= {20'd0, mul_a} * {48'd0, mul_b};
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         ppr_ff      <= espmd_pkg::PPR_RESET;
         kp_ff       <= espmd_pkg::KP_RESET;
         ig_ff       <= espmd_pkg::IG_RESET;
         vmax_ff     <= espmd_pkg::VMAX_RESET;
         rev_ff      <= 1'b0;
         last_ff     <= '0;
         count_ff    <= '0;
         spd_last_ff <= '0;
         spd_prev_ff <= '0;
         median_ff   <= '0;
         sum_ff      <= '0;
         rv_ff       <= 1'b0;
         dcnt_ff     <= '0;
         ccnt_ff     <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               espmd_pkg::CSR_PULSES_PER_REV:   ppr_ff  <= csr_wdata[15:0];
               espmd_pkg::CSR_KP_UV:            kp_ff   <= csr_wdata;
               espmd_pkg::CSR_INT_GAIN_Q16:     ig_ff   <= csr_wdata[15:0];
               espmd_pkg::CSR_VMAX_MV:          vmax_ff <= csr_wdata[15:0];
               espmd_pkg::CSR_REVERSE_POLARITY: rev_ff  <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         // In S_DONE the output register is reloaded instead of emptied.
         if (rv_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rv_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff  <= req_ch.action;
                  chb_ff   <= req_ch.channel_b;
                  drive_ff <= '0;
                  duty_ff  <= '0;
                  pa_ff    <= 1'b0;
                  pb_ff    <= 1'b0;
                  e_ff     <= 25'(req_ch.target_speed) - 25'(median_ff);
                  if (!req_ch.action) begin
                     period_ff <= req_ch.time_us - last_ff;
                     last_ff   <= req_ch.time_us;
                     count_ff  <= req_ch.channel_b ? count_ff - 32'd1 : count_ff + 32'd1;
                     state_ff  <= S_EMUL;
                  end else begin
                     state_ff <= S_TSUM;
                  end
               end
            end
            S_EMUL: state_ff <= S_SPD;
            S_SPD: begin
               if (prod_ff[47:0] == 48'd0) begin
                  quo_ff   <= {40'd0, espmd_pkg::SPEED_FULL};
                  state_ff <= S_SPDF;
               end else begin
                  rem_ff   <= '0;
                  quo_ff   <= espmd_pkg::SPEED_NUM;
                  dsr_ff   <= prod_ff[47:0];
                  ret_ff   <= S_SPDF;
                  state_ff <= S_DIV;
               end
            end
            S_SPDF: begin
               mg  = (quo_ff > {40'd0, espmd_pkg::SPEED_FULL}) ? espmd_pkg::SPEED_FULL
                                                                : quo_ff[23:0];
               v   = chb_ff ? -$signed(mg) : $signed(mg);
               mn  = (v < spd_last_ff) ? v : spd_last_ff;
               mx  = (v > spd_last_ff) ? v : spd_last_ff;
               lo2 = (mx < spd_prev_ff) ? mx : spd_prev_ff;
               median_ff   <= (mn > lo2) ? mn : lo2;
               spd_prev_ff <= spd_last_ff;
               spd_last_ff <= v;
               state_ff    <= S_PMUL;
            end
            S_TSUM: begin
               s49 = 49'(sum_ff) + 49'(e_ff);
               if (s49[48] != s49[47]) begin
                  sum_ff <= s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
               end else begin
                  sum_ff <= s49[47:0];
               end
               state_ff <= S_TMUL;
            end
            S_TMUL: state_ff <= S_TCOMB;
            S_TCOMB: begin
               m1 = prod_ff[63:0];
               m2 = {23'd0, (e_ff[24] ? 25'd0 - e_ff : e_ff), 16'd0};
               if (sum_ff[47] == e_ff[24]) begin
                  mm = m1 + m2;
                  neg_ff <= sum_ff[47];
               end else if (m1 >= m2) begin
                  mm = m1 - m2;
                  neg_ff <= sum_ff[47];
               end else begin
                  mm = m2 - m1;
                  neg_ff <= e_ff[24];
               end
               // Dividing by 125 * 2^23: the low 23 bits bypass the divide by 125.
               low_ff   <= mm[22:0];
               c_x_ff   <= {7'd0, mm[63:23]};
               c_r_ff   <= '0;
               ret_ff   <= S_MF;
               state_ff <= S_CMUL;
            end
            S_MF: begin
               q_ff     <= c_q_ff[33:0];
               state_ff <= S_KQ;
            end
            S_KQ: state_ff <= S_KR;
            S_KR: begin
               kq_ff    <= prod_ff[53:0];
               state_ff <= S_KRD;
            end
            S_KRD: begin
               klo_ff   <= prod_ff[42:23];
               state_ff <= S_KRS;
            end
            S_KRS: begin
               // kp times the remainder, over 2^23 and then over 125.
               c_x_ff   <= {21'd0, prod_ff[26:0]} + {28'd0, klo_ff};
               c_r_ff   <= '0;
               ret_ff   <= S_KRF;
               state_ff <= S_CMUL;
            end
            S_KRF: begin
               mfull = 55'(kq_ff) + 55'(c_q_ff);
               mg16  = (mfull > 55'(vmax_ff)) ? vmax_ff : mfull[15:0];
               ng    = neg_ff && (mg16 != 16'd0);
               mag_ff   <= mg16;
               drive_ff <= ng ? -$signed({1'b0, mg16}) : $signed({1'b0, mg16});
               pa_ff    <= !ng ^ rev_ff;
               pb_ff    <= ng ^ rev_ff;
               duty_ff  <= '0;
               state_ff <= (vmax_ff == 16'd0) ? S_PMUL : S_DMUL;
            end
            S_DMUL: state_ff <= S_DDIV;
            S_DDIV: begin
               rem_ff   <= '0;
               quo_ff   <= prod_ff[63:0];
               dsr_ff   <= {32'd0, vmax_ff};
               ret_ff   <= S_DUTYF;
               state_ff <= S_DIV;
            end
            S_DUTYF: begin
               duty_ff  <= FS - quo_ff[DUTY_BITS-1:0];
               state_ff <= S_PMUL;
            end
            S_PMUL: state_ff <= S_PDIV;
            S_PDIV: begin
               rem_ff   <= '0;
               quo_ff   <= prod_ff[63:0];
               dsr_ff   <= {32'd0, ppr_eff};
               ret_ff   <= S_POSF;
               state_ff <= S_DIV;
            end
            S_POSF: begin
               pos_ff   <= count_ff[31] ? -$signed(quo_ff[47:0]) : $signed(quo_ff[47:0]);
               state_ff <= S_DONE;
            end
            S_DIV: begin
               rem_ff  <= div_ge ? (div_try - {1'b0, dsr_ff}) : div_try;
               quo_ff  <= {quo_ff[62:0], div_ge};
               dcnt_ff <= dcnt_ff + 6'd1;
               if (dcnt_ff == 6'd63) begin
                  state_ff <= ret_ff;
               end
            end
            S_CMUL: state_ff <= S_CSTEP;
            S_CSTEP: begin
               qd   = prod_ff[29:22];
               crem = c_v - ({qd, 7'd0} - {5'd0, qd, 2'd0} + {7'd0, qd});
               c_r_ff <= crem[6:0];
               c_q_ff <= {c_q_ff[39:0], qd};
               c_x_ff <= {c_x_ff[39:0], 8'd0};
               if (ccnt_ff == 3'd5) begin
                  ccnt_ff  <= 3'd0;
                  state_ff <= ret_ff;
               end else begin
                  ccnt_ff  <= ccnt_ff + 3'd1;
                  state_ff <= S_CMUL;
               end
            end
            S_DONE: begin
               if (!rv_ff || rsp_ch.ready) begin
                  rv_ff    <= 1'b1;
                  ok_ff    <= kind_ff;
                  otick_ff <= count_ff;
                  omed_ff  <= median_ff;
                  opos_ff  <= pos_ff;
                  odrv_ff  <= drive_ff;
                  oduty_ff <= duty_ff;
                  opa_ff   <= pa_ff;
                  opb_ff   <= pb_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rv_ff;
   assign rsp_ch.kind         = ok_ff;
   assign rsp_ch.tick_total   = otick_ff;
   assign rsp_ch.speed_median = omed_ff;
   assign rsp_ch.position_q4  = opos_ff;
   assign rsp_ch.drive_mv     = odrv_ff;
   assign rsp_ch.duty         = oduty_ff;
   assign rsp_ch.pin_a        = opa_ff;
   assign rsp_ch.pin_b        = opb_ff;

   `ESPMD_ASSERT(a_accept_busy, clock, reset, (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
   `ESPMD_NEVER(a_div_count_idle, clock, reset, (dcnt_ff != 6'd0) && (state_ff != S_DIV))
   `ESPMD_NEVER(a_digit_count_idle, clock, reset, (ccnt_ff != 3'd0) && (state_ff != S_CMUL) && (state_ff != S_CSTEP))
   `ESPMD_ASSERT(a_done_loads, clock, reset, ((state_ff == S_DONE) && (!rv_ff || rsp_ch.ready)) |=> rv_ff)
   `ESPMD_NEVER(a_pins_equal, clock, reset, rv_ff && ok_ff && (opa_ff == opb_ff))

endmodule

@@ test/encoder_speed_pi_motor_drive_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pi_motor_drive_tb
// Drives encoder edge and control tick transactions into the speed loop and
// checks every result against a predictor of the speed, position and drive.
// ----------------------------------------------------------------------------
module encoder_speed_pi_motor_drive_tb;

   localparam int DUTY_BITS = 10;
   localparam int IDLE_TAIL = 400;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic               action;
      logic [31:0]        time_us;
      logic               channel_b;
      logic signed [23:0] target_speed;
   } motor_cmd_type;

   typedef struct packed {
      logic                 kind;
      logic signed [31:0]   tick_total;
      logic signed [23:0]   speed_median;
      logic signed [47:0]   position_q4;
      logic signed [16:0]   drive_mv;
      logic [DUTY_BITS-1:0] duty;
      logic                 pin_a;
      logic                 pin_b;
   } motor_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [espmd_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [espmd_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   espmd_req_if req_ch();
   espmd_rsp_if #(.DUTY_BITS(DUTY_BITS)) rsp_ch();

   encoder_speed_pi_motor_drive #(.DUTY_BITS(DUTY_BITS)) i_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor copy of registers and loop state.
   logic [15:0] ppr;
   logic [19:0] kp;
   logic [15:0] igain;
   logic [15:0] vmax;
   logic        swap_pins;
   logic [31:0] prev_edge;
   logic [31:0] enc_count;
   logic signed [23:0] spd_new, spd_old, spd_med;
   logic signed [47:0] err_acc;

   motor_cmd_type    cmd_queue[$];
   motor_status_type status_queue[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int stall_cycles = 0;
   int results_seen = 0;

   function automatic longint med3(longint a, longint b, longint c);
      longint lo, hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (hi < c) ? hi : ((lo > c) ? lo : c);
   endfunction

   function automatic motor_status_type predict_status(motor_cmd_type c);
      motor_status_type r;
      longint pe, cnt, mag, v, e, s, m1, m2, m, dmag, fs, vm;
      logic [31:0] period;
      logic [63:0] den, q, um;
      logic neg, s1, s2;
      r = '0;
      pe = (ppr == 0) ? 1 : ppr;
      if (c.action == 1'b0) begin
         period = c.time_us - prev_edge;
         prev_edge = c.time_us;
         enc_count = c.channel_b ? enc_count - 1 : enc_count + 1;
         den = 64'(period) * 64'(pe);
         if (den == 0) mag = 8388607;
         else begin
            q = 64'd5760000000 / den;
            mag = (q > 64'd8388607) ? 8388607 : longint'(q);
         end
         v = c.channel_b ? -mag : mag;
         spd_med = 24'(med3(v, spd_new, spd_old));
         spd_old = spd_new;
         spd_new = 24'(v);
      end else begin
         e = longint'(c.target_speed) - longint'(spd_med);
         s = longint'(err_acc) + e;
         if (s > 64'sd140737488355327) s = 64'sd140737488355327;
         if (s < -64'sd140737488355328) s = -64'sd140737488355328;
         err_acc = 48'(s);
         s1 = s < 0;
         s2 = e < 0;
         m1 = (s1 ? -s : s) * longint'(igain);
         m2 = (s2 ? -e : e) * 65536;
         if (s1 == s2) begin m = m1 + m2; neg = s1; end
         else if (m1 >= m2) begin m = m1 - m2; neg = s1; end
         else begin m = m2 - m1; neg = s2; end
         um = 64'(m);
         dmag = longint'(64'(kp) * (um / 64'd1048576000)
                + (64'(kp) * (um % 64'd1048576000)) / 64'd1048576000);
         vm = vmax;
         if (dmag > vm) dmag = vm;
         if (dmag == 0) neg = 1'b0;
         r.drive_mv = neg ? 17'(-dmag) : 17'(dmag);
         fs = (1 << DUTY_BITS) - 1;
         r.duty = (vm == 0) ? '0 : DUTY_BITS'(fs - ((vm - dmag) * fs) / vm);
         r.pin_a = !neg ^ swap_pins;
         r.pin_b = neg ^ swap_pins;
      end
      cnt = longint'($signed(enc_count));
      r.kind = c.action;
      r.tick_total = enc_count;
      r.speed_median = spd_med;
      r.position_q4 = 48'((cnt * 5760) / pe);
      return r;
   endfunction

   task automatic write_reg(espmd_pkg::csr_index_type idx,
                            logic [espmd_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         espmd_pkg::CSR_PULSES_PER_REV:   ppr = val[15:0];
         espmd_pkg::CSR_KP_UV:            kp = val[19:0];
         espmd_pkg::CSR_INT_GAIN_Q16:     igain = val[15:0];
         espmd_pkg::CSR_VMAX_MV:          vmax = val[15:0];
         espmd_pkg::CSR_REVERSE_POLARITY: swap_pins = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || status_queue.size() != 0) @(posedge clock);
      repeat (IDLE_TAIL) @(posedge clock);
   endtask

   function automatic motor_cmd_type edge_cmd(logic [31:0] t, logic b);
      motor_cmd_type c;
      c = '0;
      c.action = 1'b0;
      c.time_us = t;
      c.channel_b = b;
      c.target_speed = 24'($urandom);
      return c;
   endfunction

   function automatic motor_cmd_type tick_cmd(logic signed [23:0] tgt);
      motor_cmd_type c;
      c = '0;
      c.action = 1'b1;
      c.time_us = $urandom;
      c.channel_b = 1'($urandom_range(0, 1));
      c.target_speed = tgt;
      return c;
   endfunction

   // Driver: while the queue holds transactions the valid is up, except when send_idle_pct randomly holds it low.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            status_queue.push_back(predict_status(cmd_queue.pop_front()));
         end
         if ((!req_ch.valid || req_ch.ready) && cmd_queue.size() != 0
             && (!req_ch.valid || req_ch.ready)) begin
            if (req_ch.valid && req_ch.ready && cmd_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if ($urandom_range(0, 99) < send_idle_pct) begin
               req_ch.valid <= 1'b0;
            end else begin
               req_ch.valid <= 1'b1;
               {req_ch.action, req_ch.time_us, req_ch.channel_b, req_ch.target_speed}
                  <= cmd_queue[0];
            end
         end else if (req_ch.valid && req_ch.ready) begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor and receiver stall.
   always @(posedge clock) begin
      motor_status_type got, want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.kind, rsp_ch.tick_total, rsp_ch.speed_median,
                   rsp_ch.position_q4, rsp_ch.drive_mv, rsp_ch.duty,
                   rsp_ch.pin_a, rsp_ch.pin_b};
            results_seen <= results_seen + 1;
            if (status_queue.size() == 0) begin
               $display("%0t: unexpected result %p", $time, got);
               errors <= errors + 1;
            end else begin
               want = status_queue.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, got);
                  errors <= errors + 1;
               end
            end
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction accepted for %0d cycles", $time, stall_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic random_phase(int n);
      logic [31:0] t;
      int k;
      t = prev_edge;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 45) begin
            t = t + $urandom_range(1, 20000);
            cmd_queue.push_back(edge_cmd(t, $urandom_range(0, 9) < 3));
         end else if (k < 50) begin
            t = $urandom;
            cmd_queue.push_back(edge_cmd(t, 1'($urandom_range(0, 1))));
         end else if (k < 92) begin
            cmd_queue.push_back(tick_cmd(24'($signed($urandom_range(0, 40000)) - 20000)));
         end else begin
            cmd_queue.push_back(tick_cmd(24'($urandom)));
         end
      end
      wait_drained();
   endtask

   initial begin
      ppr = espmd_pkg::PPR_RESET; kp = espmd_pkg::KP_RESET;
      igain = espmd_pkg::IG_RESET; vmax = espmd_pkg::VMAX_RESET;
      swap_pins = 1'b0;
      prev_edge = '0; enc_count = '0;
      spd_new = '0; spd_old = '0; spd_med = '0; err_acc = '0;
      req_ch.valid = 1'b0; req_ch.action = 1'b0; req_ch.time_us = '0;
      req_ch.channel_b = 1'b0; req_ch.target_speed = '0;
      rsp_ch.ready = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero period, wrap, both directions, ties and extreme targets.
      cmd_queue.push_back(edge_cmd(32'd0, 1'b0));
      cmd_queue.push_back(edge_cmd(32'd1000, 1'b0));
      cmd_queue.push_back(edge_cmd(32'd1000, 1'b1));
      cmd_queue.push_back(edge_cmd(32'hFFFF_FFFF, 1'b0));
      cmd_queue.push_back(edge_cmd(32'd5, 1'b1));
      cmd_queue.push_back(edge_cmd(32'h8000_0005, 1'b1));
      cmd_queue.push_back(edge_cmd(32'h8000_1005, 1'b0));
      cmd_queue.push_back(tick_cmd(24'sd0));
      cmd_queue.push_back(tick_cmd(24'sd8388607));
      cmd_queue.push_back(tick_cmd(-24'sd8388608));
      cmd_queue.push_back(tick_cmd(24'sd300));
      cmd_queue.push_back(tick_cmd(-24'sd300));
      wait_drained();
      write_reg(espmd_pkg::CSR_REVERSE_POLARITY, 20'd1);
      write_reg(espmd_pkg::CSR_VMAX_MV, 20'd0);
      write_reg(espmd_pkg::CSR_PULSES_PER_REV, 20'd0);
      cmd_queue.push_back(edge_cmd(32'h8000_2005, 1'b0));
      cmd_queue.push_back(tick_cmd(24'sd5000));
      cmd_queue.push_back(tick_cmd(-24'sd5000));
      wait_drained();

      send_idle_pct = 30; recv_idle_pct = 87;
      write_reg(espmd_pkg::CSR_PULSES_PER_REV, 20'd1);
      write_reg(espmd_pkg::CSR_KP_UV, 20'd1000000);
      write_reg(espmd_pkg::CSR_INT_GAIN_Q16, 20'd65535);
      write_reg(espmd_pkg::CSR_VMAX_MV, 20'd65535);
      random_phase(450);

      send_idle_pct = 87; recv_idle_pct = 30;
      write_reg(espmd_pkg::CSR_PULSES_PER_REV, 20'd65535);
      write_reg(espmd_pkg::CSR_KP_UV, 20'd0);
      write_reg(espmd_pkg::CSR_INT_GAIN_Q16, 20'd0);
      write_reg(espmd_pkg::CSR_VMAX_MV, 20'd1);
      write_reg(espmd_pkg::CSR_REVERSE_POLARITY, 20'd0);
      random_phase(450);

      send_idle_pct = 0; recv_idle_pct = 0;
      write_reg(espmd_pkg::CSR_PULSES_PER_REV, 20'd1080);
      write_reg(espmd_pkg::CSR_KP_UV, 20'd14000);
      write_reg(espmd_pkg::CSR_INT_GAIN_Q16, 20'd1049);
      write_reg(espmd_pkg::CSR_VMAX_MV, 20'd11100);
      random_phase(450);

      write_reg(espmd_pkg::CSR_PULSES_PER_REV, 20'($urandom_range(1, 65535)));
      write_reg(espmd_pkg::CSR_KP_UV, 20'($urandom_range(0, 1000000)));
      write_reg(espmd_pkg::CSR_INT_GAIN_Q16, 20'($urandom_range(0, 65535)));
      write_reg(espmd_pkg::CSR_VMAX_MV, 20'($urandom_range(1, 65535)));
      write_reg(espmd_pkg::CSR_REVERSE_POLARITY, 20'($urandom_range(0, 1)));
      random_phase(480);

      $display("Ran %0d results over edges and ticks at five register settings,",
               results_seen);
      $display("including zero period, zero vmax and both bridge polarities.");
      if (errors == 0 && status_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
